### rtl/stt_pkg.sv
// Shared types and constants for the string split tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int unsigned AddrBits   = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrBits   = 2;

  localparam logic [AddrBits-1:0] AddrSplitMode = 4'h0;
  localparam logic [AddrBits-1:0] AddrDelimiter = 4'h4;
  localparam logic [AddrBits-1:0] AddrLimit     = 4'h8;

  localparam logic [7:0] DelimReset = 8'd44;

  typedef struct packed {
    logic        split_mode;
    logic [7:0]  delimiter_byte;
    logic [16:0] split_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       char_present;
    logic       end_of_string;
    logic       is_sep;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_byte_valid;
    logic        token_done;
    logic [15:0] empty_before;
    logic [15:0] token_index;
    logic        string_done;
  } result_t;

endpackage

### rtl/stt_front.sv
// Front end: accepts input items and tags separator bytes.
`timescale 1ns / 1ps

module stt_front import stt_pkg::*; (
  input  logic       in_valid_i,
  input  logic [7:0] char_in_i,
  input  logic       char_present_i,
  input  logic       end_of_string_i,
  input  cfg_t       cfg_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output item_t      item_o
);

  logic space_w;

  assign space_w = (char_in_i == 8'h20) || ((char_in_i >= 8'h09) && (char_in_i <= 8'h0D));

  always_comb begin
    item_o.char_in       = char_in_i;
    item_o.char_present  = char_present_i;
    item_o.end_of_string = end_of_string_i;
    item_o.is_sep        = cfg_i.split_mode ? (char_in_i == cfg_i.delimiter_byte) : space_w;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

### rtl/stt_queue.sv
// Short item queue between the front and back ends.
`timescale 1ns / 1ps

module stt_queue import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  full_o,
  output logic  empty_o
);

  item_t                mem_q [QueueDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPtrBits:0]    count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (QPtrBits + 1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/stt_back.sv
// Back end: token counting, limit handling and the output register.
`timescale 1ns / 1ps

module stt_back import stt_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    q_empty_i,
  output logic    pop_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t res_o
);

  localparam int unsigned W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned LW = W + 1;

  logic [COUNT_BITS-1:0] tc_q, tc_d;
  logic [COUNT_BITS-1:0] pe_q, pe_d;
  logic                  thb_q, thb_d;
  logic                  ab_q, ab_d;
  logic                  out_valid_q;
  result_t               res_q, res_d;
  logic                  lim_pos, lim_zero;

  function automatic logic [15:0] sat16(logic [COUNT_BITS-1:0] v);
    logic [W-1:0] ve;
    ve = W'(v);
    if (ve > W'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return ve[15:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
                                                    logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[COUNT_BITS]) begin
      return '1;
    end
    return s[COUNT_BITS-1:0];
  endfunction

  function automatic logic lim_hit(logic [COUNT_BITS-1:0] tc, logic [15:0] lim);
    return (LW'(tc) + LW'(1)) == LW'(lim);
  endfunction

  assign lim_pos  = !cfg_i.split_limit[16] && (cfg_i.split_limit[15:0] != '0);
  assign lim_zero = (cfg_i.split_limit == '0);

  assign pop_o       = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    tc_d  = tc_q;
    pe_d  = pe_q;
    thb_d = thb_q;
    ab_d  = ab_q;
    res_d = '0;
    res_d.token_index = sat16(tc_q);
    if (item_i.char_present) begin
      if (cfg_i.split_mode && lim_pos && lim_hit(tc_q, cfg_i.split_limit[15:0])) begin
        ab_d = 1'b1;
      end
      if (item_i.is_sep && !ab_d) begin
        if (cfg_i.split_mode) begin
          if (thb_q || !lim_zero) begin
            res_d.token_done = 1'b1;
            tc_d = sat_add(tc_q, COUNT_BITS'(1));
          end else begin
            pe_d = sat_add(pe_q, COUNT_BITS'(1));
          end
        end else if (thb_q) begin
          res_d.token_done = 1'b1;
          tc_d = sat_add(tc_q, COUNT_BITS'(1));
        end
        thb_d = 1'b0;
      end else begin
        if (!thb_q) begin
          res_d.empty_before = sat16(pe_q);
          tc_d = sat_add(tc_q, pe_q);
          pe_d = '0;
          if (!cfg_i.split_mode && lim_pos && lim_hit(tc_d, cfg_i.split_limit[15:0])) begin
            ab_d = 1'b1;
          end
        end
        thb_d = 1'b1;
        res_d.out_byte       = item_i.char_in;
        res_d.out_byte_valid = 1'b1;
        res_d.token_index    = sat16(tc_d);
      end
    end
    if (item_i.end_of_string) begin
      if (thb_d) begin
        res_d.token_done  = 1'b1;
        res_d.token_index = sat16(tc_d);
      end
      res_d.string_done = 1'b1;
      tc_d  = '0;
      pe_d  = '0;
      thb_d = 1'b0;
      ab_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q        <= '0;
      pe_q        <= '0;
      thb_q       <= 1'b0;
      ab_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        tc_q  <= tc_d;
        pe_q  <= pe_d;
        thb_q <= thb_d;
        ab_q  <= ab_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

### rtl/string_split_tokenizer_top.sv
// Top level of the string split tokenizer: register port, front end, queue, back end.
// Accepted items pass through the queue into the back end's registered output.
// Throughput: one item per cycle while the output is not stalled.
// A four-item queue decouples input acceptance from output stalls.
// Reset (rst_ni low, asynchronous) empties the queue, clears token state and restores
// split_mode 0, delimiter_byte 44 and split_limit 0.
`timescale 1ns / 1ps

module string_split_tokenizer_top import stt_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_in_i,
  input  logic                char_present_i,
  input  logic                end_of_string_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                out_byte_valid_o,
  output logic                token_done_o,
  output logic [15:0]         empty_before_o,
  output logic [15:0]         token_index_o,
  output logic                string_done_o
);

  cfg_t    cfg_q;
  item_t   front_item, queue_item;
  logic    push, pop, q_full, q_empty;
  result_t res;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.split_mode     <= 1'b0;
      cfg_q.delimiter_byte <= DelimReset;
      cfg_q.split_limit    <= '0;
    end else if (wr_en) begin
      case (paddr)
        AddrSplitMode: cfg_q.split_mode     <= pwdata[0];
        AddrDelimiter: cfg_q.delimiter_byte <= pwdata[7:0];
        AddrLimit:     cfg_q.split_limit    <= pwdata[16:0];
        default:       cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrSplitMode: prdata = {31'd0, cfg_q.split_mode};
      AddrDelimiter: prdata = {24'd0, cfg_q.delimiter_byte};
      AddrLimit:     prdata = {{15{cfg_q.split_limit[16]}}, cfg_q.split_limit};
      default:       prdata = '0;
    endcase
  end

  stt_front u_front (
    .in_valid_i      (in_valid_i),
    .char_in_i       (char_in_i),
    .char_present_i  (char_present_i),
    .end_of_string_i (end_of_string_i),
    .cfg_i           (cfg_q),
    .q_full_i        (q_full),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .item_o          (front_item)
  );

  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  stt_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (queue_item),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign out_byte_o       = res.out_byte;
  assign out_byte_valid_o = res.out_byte_valid;
  assign token_done_o     = res.token_done;
  assign empty_before_o   = res.empty_before;
  assign token_index_o    = res.token_index;
  assign string_done_o    = res.string_done;

`ifndef ASSERT_OFF
  a_byte_done_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_byte_valid_o && !string_done_o |-> !token_done_o)
    else $error("token closed on a token byte before end of string");

  a_empties_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (empty_before_o != 16'd0) |-> out_byte_valid_o)
    else $error("deferred empties reported without a token byte");

  a_byte_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_byte_valid_o |-> (out_byte_o == 8'd0))
    else $error("out_byte nonzero on a non-token item");
`endif

endmodule
